### sv/mtp_pkg.sv
// mtp_pkg: shared types, constants and tables of the melody text parser
// used by mtp_front, mtp_queue, mtp_back and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mtp_pkg;

    localparam int POSITION_BITS = 16;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [14:0] START_TEMPO_RESET = 15'd120;
    localparam logic [3:0]  CODE_PAUSE = 4'd0;
    localparam logic [3:0]  CODE_E     = 4'd5;
    localparam logic [3:0]  CODE_B     = 4'd12;
    localparam logic [3:0]  CODE_TEMPO = 4'd13;
    localparam logic [3:0]  CODE_SHIFT = 4'd14;

    localparam logic [1:0] KIND_NOTE  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_BAD_SYMBOL = 3'd0;
    localparam logic [2:0] ERR_SHARP      = 3'd1;
    localparam logic [2:0] ERR_EQUALS     = 3'd2;
    localparam logic [2:0] ERR_AT         = 3'd3;
    localparam logic [2:0] ERR_SLASH      = 3'd4;
    localparam logic [2:0] ERR_ZERO_DIV   = 3'd5;

    localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

    typedef enum logic [3:0] {
        PH_START, PH_PRE_BAR, PH_POST_BAR, PH_AFTER_LETTER, PH_AFTER_SHARP,
        PH_SET_START, PH_SET_DIG, PH_OCT_START, PH_OCT_DIG,
        PH_NUM_START, PH_NUM_DIG, PH_DEN_START, PH_DEN_DIG
    } phase_t;

    typedef enum logic [3:0] {
        B_IDLE, B_IDX_GO, B_IDX_WAIT, B_T_GO, B_T_WAIT,
        B_MUL, B_DUR_GO, B_DUR_WAIT, B_OUT
    } back_state_t;

    // one parsed token handed from the parser to the tone calculator
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  note_code;
        logic [15:0] octave;
        logic [15:0] transpose;
        logic [15:0] tempo;
        logic [15:0] numerator;
        logic [15:0] denominator;
        logic [15:0] bar_number;
        logic [2:0]  error_code;
        logic [15:0] error_pos;
        logic        last;
    } job_t;

    // bit 4 flags a valid symbol letter
    function automatic logic [4:0] letter_code(input logic [7:0] c);
        logic [7:0] lc;
        logic [4:0] r;
        begin
            lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
            case (lc)
                "p":      r = {1'b1, CODE_PAUSE};
                "c":      r = 5'h11;
                "d":      r = 5'h13;
                "e":      r = {1'b1, CODE_E};
                "f":      r = 5'h16;
                "g":      r = 5'h18;
                "a":      r = 5'h1A;
                "b", "h": r = {1'b1, CODE_B};
                "t":      r = {1'b1, CODE_TEMPO};
                "s":      r = {1'b1, CODE_SHIFT};
                default:  r = 5'h00;
            endcase
            return r;
        end
    endfunction

    // tones of octave 5, C first
    function automatic logic [10:0] tone_base(input logic [3:0] i);
        logic [10:0] r;
        begin
            case (i)
                4'd0:    r = 11'd1047;
                4'd1:    r = 11'd1109;
                4'd2:    r = 11'd1175;
                4'd3:    r = 11'd1245;
                4'd4:    r = 11'd1319;
                4'd5:    r = 11'd1397;
                4'd6:    r = 11'd1480;
                4'd7:    r = 11'd1568;
                4'd8:    r = 11'd1661;
                4'd9:    r = 11'd1760;
                4'd10:   r = 11'd1865;
                default: r = 11'd1976;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

### sv/mtp_div.sv
// mtp_div: restoring unsigned divider, one quotient bit per cycle
// 34-bit dividend by 16-bit divisor; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module mtp_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [33:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [33:0]      quotient
);
    logic [33:0] dvd_reg, dvd_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[15:0], dvd_reg[33]};
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 6'd34;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial - {1'b0, dsr_reg};
                dvd_next = {dvd_reg[32:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                dvd_next = {dvd_reg[32:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

### sv/mtp_queue.sv
// mtp_queue: short job queue between parser and tone calculator
// depends on mtp_pkg for job_t and QUEUE_DEPTH
`timescale 1ns / 1ps
`default_nettype none

module mtp_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  mtp_pkg::job_t    push_data,
    output logic             full,
    input  wire logic        pop,
    output mtp_pkg::job_t    pop_data,
    output logic             empty
);
    import mtp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    job_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [PW:0]   cnt_reg, cnt_next;

    assign full     = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        if (pop)
            rd_next = (rd_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + (PW+1)'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - (PW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

endmodule

`default_nettype wire

### sv/mtp_front.sv
// mtp_front: character parser, walks one parse phase per cycle while the queue has room
// depends on mtp_pkg; pushes note, end and error jobs into mtp_queue
`timescale 1ns / 1ps
`default_nettype none

module mtp_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [14:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  ch,
    input  wire logic        first,
    output logic             push,
    output mtp_pkg::job_t    push_data,
    input  wire logic        q_full
);
    import mtp_pkg::*;

    localparam int PB = POSITION_BITS;

    logic [14:0]   st_tempo_reg;
    phase_t        phase_reg, phase_next;
    logic [15:0]   bar_reg, bar_next;
    logic [15:0]   tempo_reg, tempo_next;
    logic [15:0]   transp_reg, transp_next;
    logic [3:0]    pend_reg, pend_next;
    logic [15:0]   oct_reg, oct_next;
    logic [15:0]   acc_reg, acc_next;
    logic          neg_reg, neg_next;
    logic [15:0]   num_reg, num_next;
    logic [PB-1:0] idx_reg, idx_next;
    logic          halt_reg, halt_next;
    logic          busy_reg, busy_next;
    logic [7:0]    ch_reg, ch_next;

    logic          is_digit, err, fin, want;
    logic [2:0]    err_code;
    logic [4:0]    lcode;
    logic [18:0]   acc_wide;
    logic [15:0]   val;
    job_t          job;

    assign in_ready = !busy_reg;
    assign is_digit = (ch_reg >= "0") && (ch_reg <= "9");
    assign lcode    = letter_code(ch_reg);
    assign acc_wide = 19'(acc_reg) * 19'd10 + 19'(ch_reg - 8'd48);
    assign val      = neg_reg ? 16'(-acc_reg) :
                      (acc_reg > 16'd32767 ? 16'd32767 : acc_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        bar_next    = bar_reg;
        tempo_next  = tempo_reg;
        transp_next = transp_reg;
        pend_next   = pend_reg;
        oct_next    = oct_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        num_next    = num_reg;
        idx_next    = idx_reg;
        halt_next   = halt_reg;
        busy_next   = busy_reg;
        ch_next     = ch_reg;
        err         = 1'b0;
        err_code    = ERR_BAD_SYMBOL;
        fin         = 1'b0;
        want        = 1'b0;
        job         = '0;
        job.bar_number = bar_reg;

        if (!busy_reg)
        begin
            if (in_valid)
            begin
                ch_next = ch;
                if (first)
                begin
                    phase_next  = PH_START;
                    bar_next    = '0;
                    tempo_next  = 16'(st_tempo_reg);
                    transp_next = '0;
                    pend_next   = '0;
                    oct_next    = '0;
                    acc_next    = '0;
                    neg_next    = 1'b0;
                    num_next    = '0;
                    idx_next    = '0;
                    halt_next   = 1'b0;
                end
                busy_next = first || !halt_reg;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (ch_reg == 8'd0)
                    begin
                        want      = 1'b1;
                        job.kind  = KIND_END;
                        job.last  = 1'b1;
                        halt_next = 1'b1;
                        fin       = 1'b1;
                    end
                    else
                        phase_next = PH_PRE_BAR;
                end
                PH_PRE_BAR, PH_POST_BAR:
                begin
                    if (ch_reg == " ")
                        fin = 1'b1;
                    else if (ch_reg == "|" && phase_reg == PH_PRE_BAR)
                    begin
                        if (bar_reg != 16'hFFFF)
                            bar_next = bar_reg + 16'd1;
                        phase_next = PH_POST_BAR;
                        fin        = 1'b1;
                    end
                    else if (!lcode[4])
                    begin
                        err      = 1'b1;
                        err_code = ERR_BAD_SYMBOL;
                    end
                    else
                    begin
                        pend_next  = lcode[3:0];
                        phase_next = PH_AFTER_LETTER;
                        fin        = 1'b1;
                    end
                end
                PH_AFTER_LETTER:
                begin
                    if (ch_reg == "#")
                    begin
                        if (pend_reg == CODE_PAUSE || pend_reg == CODE_E ||
                            pend_reg == CODE_B || pend_reg == CODE_TEMPO ||
                            pend_reg == CODE_SHIFT)
                        begin
                            err      = 1'b1;
                            err_code = ERR_SHARP;
                        end
                        else
                        begin
                            pend_next  = pend_reg + 4'd1;
                            phase_next = PH_AFTER_SHARP;
                            fin        = 1'b1;
                        end
                    end
                    else
                        phase_next = PH_AFTER_SHARP;
                end
                PH_AFTER_SHARP:
                begin
                    acc_next = '0;
                    neg_next = 1'b0;
                    if (pend_reg == CODE_TEMPO || pend_reg == CODE_SHIFT)
                    begin
                        if (ch_reg != "=")
                        begin
                            err      = 1'b1;
                            err_code = ERR_EQUALS;
                        end
                        else
                        begin
                            phase_next = PH_SET_START;
                            fin        = 1'b1;
                        end
                    end
                    else if (pend_reg == CODE_PAUSE)
                    begin
                        if (ch_reg != "@")
                        begin
                            err      = 1'b1;
                            err_code = ERR_AT;
                        end
                        else
                        begin
                            phase_next = PH_NUM_START;
                            fin        = 1'b1;
                        end
                    end
                    else
                        phase_next = PH_OCT_START;
                end
                PH_SET_START, PH_OCT_START, PH_NUM_START, PH_DEN_START:
                begin
                    if (ch_reg == "-")
                    begin
                        neg_next = 1'b1;
                        fin      = 1'b1;
                    end
                    phase_next = phase_t'(phase_reg + 4'd1);
                end
                PH_SET_DIG:
                begin
                    if (is_digit)
                        fin = 1'b1;
                    else
                    begin
                        if (pend_reg == CODE_TEMPO)
                            tempo_next = val;
                        else
                            transp_next = val;
                        phase_next = PH_START;
                    end
                end
                PH_OCT_DIG, PH_NUM_DIG:
                begin
                    if (is_digit)
                        fin = 1'b1;
                    else
                    begin
                        if (phase_reg == PH_OCT_DIG)
                            oct_next = val;
                        else
                            num_next = val;
                        if (ch_reg != (phase_reg == PH_OCT_DIG ? "@" : "/"))
                        begin
                            err      = 1'b1;
                            err_code = (phase_reg == PH_OCT_DIG) ? ERR_AT : ERR_SLASH;
                        end
                        else
                        begin
                            acc_next   = '0;
                            neg_next   = 1'b0;
                            phase_next = (phase_reg == PH_OCT_DIG) ? PH_NUM_START
                                                                   : PH_DEN_START;
                            fin        = 1'b1;
                        end
                    end
                end
                PH_DEN_DIG:
                begin
                    if (is_digit)
                        fin = 1'b1;
                    else if (val == '0 || tempo_reg == '0)
                    begin
                        err      = 1'b1;
                        err_code = ERR_ZERO_DIV;
                    end
                    else
                    begin
                        want            = 1'b1;
                        job.kind        = KIND_NOTE;
                        job.note_code   = pend_reg;
                        job.octave      = oct_reg;
                        job.transpose   = transp_reg;
                        job.tempo       = tempo_reg;
                        job.numerator   = num_reg;
                        job.denominator = val;
                        // the same character restarts a token: end or bad symbol follows
                        job.last = !(ch_reg == 8'd0 ||
                                     (ch_reg != " " && ch_reg != "|" && !lcode[4]));
                        phase_next = PH_START;
                    end
                end
                default:
                    phase_next = PH_START;
            endcase

            if (is_digit && (phase_reg == PH_SET_DIG || phase_reg == PH_OCT_DIG ||
                             phase_reg == PH_NUM_DIG || phase_reg == PH_DEN_DIG))
                acc_next = (acc_wide > 19'd32768) ? 16'd32768 : acc_wide[15:0];

            if (err)
            begin
                want           = 1'b1;
                job            = '0;
                job.kind       = KIND_ERROR;
                job.bar_number = bar_reg;
                job.error_code = err_code;
                job.error_pos  = 16'(idx_reg);
                job.last       = 1'b1;
                halt_next      = 1'b1;
                fin            = 1'b1;
            end
            if (fin)
            begin
                busy_next = 1'b0;
                if (idx_reg != '1)
                    idx_next = idx_reg + PB'(1);
            end

            // no room for the result: hold everything and retry
            if (want && q_full)
            begin
                phase_next  = phase_reg;
                bar_next    = bar_reg;
                tempo_next  = tempo_reg;
                transp_next = transp_reg;
                pend_next   = pend_reg;
                oct_next    = oct_reg;
                acc_next    = acc_reg;
                neg_next    = neg_reg;
                num_next    = num_reg;
                idx_next    = idx_reg;
                halt_next   = halt_reg;
                busy_next   = busy_reg;
            end
        end
    end

    assign push      = want && !q_full;
    assign push_data = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_tempo_reg <= START_TEMPO_RESET;
            phase_reg    <= PH_START;
            bar_reg      <= '0;
            tempo_reg    <= 16'(START_TEMPO_RESET);
            transp_reg   <= '0;
            pend_reg     <= '0;
            oct_reg      <= '0;
            acc_reg      <= '0;
            neg_reg      <= 1'b0;
            num_reg      <= '0;
            idx_reg      <= '0;
            halt_reg     <= 1'b1;
            busy_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                st_tempo_reg <= cfg_wdata;
            phase_reg  <= phase_next;
            bar_reg    <= bar_next;
            tempo_reg  <= tempo_next;
            transp_reg <= transp_next;
            pend_reg   <= pend_next;
            oct_reg    <= oct_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            num_reg    <= num_next;
            idx_reg    <= idx_next;
            halt_reg   <= halt_next;
            busy_reg   <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg <= ch_next;
    end

endmodule

`default_nettype wire

### sv/mtp_back.sv
// mtp_back: tone calculator, frequency by table, duration through one shared divider
// depends on mtp_pkg and mtp_div; drains jobs from mtp_queue into the output register
`timescale 1ns / 1ps
`default_nettype none

module mtp_back (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_empty,
    input  mtp_pkg::job_t    q_data,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [3:0]       note_code,
    output logic [15:0]      freq_hz,
    output logic [23:0]      duration_ms,
    output logic [15:0]      bar_number,
    output logic [2:0]       error_code,
    output logic [15:0]      error_pos,
    output logic             last
);
    import mtp_pkg::*;

    back_state_t state_reg, state_next;
    job_t        job_reg;
    logic [15:0] freq_reg, freq_next;
    logic [23:0] dur_reg, dur_next;
    logic [15:0] tq_reg, tq_next;
    logic [33:0] prod_reg, prod_next;
    logic        sign_reg, sign_next;
    logic [15:0] octq_reg, octq_next;
    logic [3:0]  semi_reg, semi_next;
    logic        ov_reg;
    logic [1:0]  o_kind_reg;
    logic [3:0]  o_note_reg;
    logic [15:0] o_freq_reg;
    logic [23:0] o_dur_reg;
    logic [15:0] o_bar_reg;
    logic [2:0]  o_err_reg;
    logic [15:0] o_pos_reg;
    logic        o_last_reg;

    logic        div_start, div_done;
    logic [33:0] div_dvd, div_q;
    logic [15:0] div_dsr;

    logic signed [21:0] idx_s;
    logic [19:0] idx_u;
    logic [35:0] q3_prod;
    logic [16:0] pq;
    logic [19:0] q12;
    logic [3:0]  pr;
    logic [15:0] oct_q;
    logic [10:0] base;
    logic [17:0] f_up;
    logic [15:0] f_calc;
    logic [15:0] mag_t, mag_n, mag_d;
    logic        out_free;

    mtp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .done      (div_done),
        .quotient  (div_q)
    );

    assign out_free = !ov_reg || out_ready;

    // pitch index, clamped at zero
    assign idx_s = 22'($signed({1'b0, job_reg.note_code})) - 22'sd1
                 + ($signed(22'($signed(job_reg.octave))) <<< 3)
                 + ($signed(22'($signed(job_reg.octave))) <<< 2)
                 + 22'($signed(job_reg.transpose));
    assign idx_u = idx_s[21] ? '0 : idx_s[19:0];

    // split by twelve: quarter the index, then divide by three with a reciprocal
    assign q3_prod = 36'(idx_u[19:2]) * 36'd174763;
    assign pq      = q3_prod[35:19];
    assign q12     = 20'({pq, 3'b000}) + 20'({pq, 2'b00});
    assign pr      = idx_u[3:0] - q12[3:0];

    assign oct_q = octq_reg;
    assign base  = tone_base(semi_reg);
    assign f_up  = 18'(base) << (oct_q - 16'd5);
    always_comb
    begin
        if (oct_q >= 16'd5)
        begin
            if (oct_q > 16'd11)
                f_calc = 16'hFFFF;
            else
                f_calc = (f_up > 18'h0FFFF) ? 16'hFFFF : f_up[15:0];
        end
        else
            f_calc = 16'(base >> (16'd5 - oct_q));
    end

    assign mag_t = job_reg.tempo[15]       ? 16'(-job_reg.tempo)       : job_reg.tempo;
    assign mag_n = job_reg.numerator[15]   ? 16'(-job_reg.numerator)   : job_reg.numerator;
    assign mag_d = job_reg.denominator[15] ? 16'(-job_reg.denominator) : job_reg.denominator;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
                if (!q_empty)
                    state_next = (q_data.kind == KIND_NOTE) ? B_IDX_GO : B_OUT;
            B_IDX_GO:
                state_next = (job_reg.note_code == CODE_PAUSE) ? B_T_GO : B_IDX_WAIT;
            B_IDX_WAIT:
                state_next = B_T_GO;
            B_T_GO:
                state_next = B_T_WAIT;
            B_T_WAIT:
                if (div_done)
                    state_next = B_MUL;
            B_MUL:
                state_next = B_DUR_GO;
            B_DUR_GO:
                state_next = B_DUR_WAIT;
            B_DUR_WAIT:
                if (div_done)
                    state_next = B_OUT;
            B_OUT:
                if (out_free)
                    state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        pop       = 1'b0;
        div_start = 1'b0;
        div_dvd   = 34'(MS_PER_MINUTE);
        div_dsr   = mag_t;
        freq_next = freq_reg;
        dur_next  = dur_reg;
        tq_next   = tq_reg;
        prod_next = prod_reg;
        sign_next = sign_reg;
        octq_next = octq_reg;
        semi_next = semi_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                pop       = !q_empty;
                freq_next = '0;
                dur_next  = '0;
            end
            B_IDX_GO:
            begin
                octq_next = pq[15:0];
                semi_next = pr;
            end
            B_IDX_WAIT:
                freq_next = f_calc;
            B_T_GO:
            begin
                div_start = 1'b1;
                div_dvd   = 34'(MS_PER_MINUTE);
                div_dsr   = mag_t;
            end
            B_T_WAIT:
                if (div_done)
                    tq_next = div_q[15:0];
            B_MUL:
            begin
                prod_next = {(32'(tq_reg) * 32'(mag_n)), 2'b00};
                sign_next = job_reg.tempo[15] ^ job_reg.numerator[15]
                          ^ job_reg.denominator[15];
            end
            B_DUR_GO:
            begin
                div_start = 1'b1;
                div_dvd   = prod_reg;
                div_dsr   = mag_d;
            end
            B_DUR_WAIT:
                if (div_done)
                begin
                    if (sign_reg)
                        dur_next = '0;
                    else
                        dur_next = (div_q > 34'hFFFFFF) ? 24'hFFFFFF : div_q[23:0];
                end
            B_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_OUT && out_free)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= q_data;
        freq_reg <= freq_next;
        dur_reg  <= dur_next;
        tq_reg   <= tq_next;
        prod_reg <= prod_next;
        sign_reg <= sign_next;
        octq_reg <= octq_next;
        semi_reg <= semi_next;
        if (state_reg == B_OUT && out_free)
        begin
            o_kind_reg <= job_reg.kind;
            o_note_reg <= job_reg.note_code;
            o_freq_reg <= freq_reg;
            o_dur_reg  <= dur_reg;
            o_bar_reg  <= job_reg.bar_number;
            o_err_reg  <= job_reg.error_code;
            o_pos_reg  <= job_reg.error_pos;
            o_last_reg <= job_reg.last;
        end
    end

    assign out_valid   = ov_reg;
    assign kind        = o_kind_reg;
    assign note_code   = o_note_reg;
    assign freq_hz     = o_freq_reg;
    assign duration_ms = o_dur_reg;
    assign bar_number  = o_bar_reg;
    assign error_code  = o_err_reg;
    assign error_pos   = o_pos_reg;
    assign last        = o_last_reg;

endmodule

`default_nettype wire

### sv/melody_text_to_tone_parser.sv
// a character walks the parser one parse phase per cycle while the queue has room
// and is dropped while the parser is halted
// a note beat splits the pitch by twelve and makes two divisions
// (60000 by tempo, product by denominator) on one divider of the tone calculator
// end and error beats skip the divider; a 2-entry queue lets the parser run ahead
// reset: parser halted until a character with first set, start tempo 120
`timescale 1ns / 1ps
`default_nettype none

module melody_text_to_tone_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [14:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  ch,
    input  wire logic        first,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [3:0]       note_code,
    output logic [15:0]      freq_hz,
    output logic [23:0]      duration_ms,
    output logic [15:0]      bar_number,
    output logic [2:0]       error_code,
    output logic [15:0]      error_pos,
    output logic             last
);
    import mtp_pkg::*;

    logic push, pop, q_full, q_empty;
    job_t push_data, pop_data;

    mtp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .first     (first),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    mtp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    mtp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .note_code   (note_code),
        .freq_hz     (freq_hz),
        .duration_ms (duration_ms),
        .bar_number  (bar_number),
        .error_code  (error_code),
        .error_pos   (error_pos),
        .last        (last)
    );

endmodule

`default_nettype wire

### tb/sv/tb.sv
// tb: self-checking bench for melody_text_to_tone_parser, random melodies against a tone predictor
// depends on mtp_pkg and the top level melody_text_to_tone_parser
`timescale 1ns / 1ps

module tb;
    import mtp_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  note;
        logic [15:0] freq;
        logic [23:0] dur;
        logic [15:0] bar;
        logic [2:0]  err;
        logic [15:0] pos;
        logic        last;
    } tone_t;

    typedef struct {
        logic [7:0]  c;
        logic        f;
        bit          typed;
        logic [1:0]  kind;
        logic [2:0]  err;
        logic [15:0] pos;
    } char_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [14:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  ch;
    logic        first;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [3:0]  note_code;
    logic [15:0] freq_hz;
    logic [23:0] duration_ms;
    logic [15:0] bar_number;
    logic [2:0]  error_code;
    logic [15:0] error_pos;
    logic        last;

    tone_t     tones_q[$];
    char_row_t rows_q[$];
    char_row_t text_q[$];
    int        fails = 0;
    int        idle_cycles = 0;
    bit        hold_req = 0;
    bit        no_stall = 0;

    // predictor state
    logic [14:0] p_start_tempo = START_TEMPO_RESET;
    phase_t      p_phase = PH_START;
    int          p_bar, p_tempo, p_shift, p_octave, p_acc, p_numer, p_pos;
    logic [3:0]  p_note;
    bit          p_neg;
    bit          p_halted = 1;

    int tone_hz[12] = '{1047, 1109, 1175, 1245, 1319, 1397, 1480, 1568, 1661, 1760, 1865, 1976};

    melody_text_to_tone_parser u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .ch(ch), .first(first),
        .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .note_code(note_code),
        .freq_hz(freq_hz), .duration_ms(duration_ms), .bar_number(bar_number),
        .error_code(error_code), .error_pos(error_pos), .last(last)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic int symbol_code(input logic [7:0] c);
        logic [7:0] lc;
        begin
            lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
            case (lc)
                "p": return CODE_PAUSE;
                "c": return 1;
                "d": return 3;
                "e": return CODE_E;
                "f": return 6;
                "g": return 8;
                "a": return 10;
                "b", "h": return CODE_B;
                "t": return CODE_TEMPO;
                "s": return CODE_SHIFT;
                default: return -1;
            endcase
        end
    endfunction

    function automatic int value_done();
        if (p_neg)
            return -p_acc;
        return (p_acc > 32767) ? 32767 : p_acc;
    endfunction

    function automatic logic [15:0] tone_freq(input logic [3:0] code);
        longint idx, oct, f;
        begin
            if (code == CODE_PAUSE)
                return 0;
            idx = longint'(code) - 1 + 12 * longint'(p_octave) + longint'(p_shift);
            if (idx < 0)
                idx = 0;
            oct = idx / 12;
            f = tone_hz[idx % 12];
            if (oct >= 5)
            begin
                if (oct - 5 > 6)
                    return 16'hFFFF;
                f = f << (oct - 5);
                return (f > 65535) ? 16'hFFFF : f[15:0];
            end
            return 16'(f >> (5 - oct));
        end
    endfunction

    function automatic logic [23:0] tone_ms(input int den);
        longint t;
        begin
            t = 60000 / longint'(p_tempo);
            t = t * 4 * longint'(p_numer);
            t = t / den;
            if (t < 0)
                return 0;
            return (t > 16777215) ? 24'hFFFFFF : t[23:0];
        end
    endfunction

    function automatic void push_tone(input logic [1:0] k, input logic [3:0] n,
                                      input logic [15:0] fq, input logic [23:0] d,
                                      input logic [2:0] e, input logic [15:0] pos);
        tone_t r;
        begin
            r = '{k, n, fq, d, p_bar[15:0], e, pos, 1'b0};
            tones_q.push_back(r);
        end
    endfunction

    // parse one accepted character and queue the tones it gives
    function automatic void parse_char(input logic [7:0] c, input logic f);
        int n, code, den;
        bit done, has_err;
        logic [2:0] ec;
        begin
            n = tones_q.size();
            done = 0;
            has_err = 0;
            ec = ERR_BAD_SYMBOL;
            if (f)
            begin
                p_phase = PH_START;
                p_bar = 0;
                p_tempo = p_start_tempo;
                p_shift = 0;
                p_note = CODE_PAUSE;
                p_octave = 0;
                p_acc = 0;
                p_neg = 0;
                p_numer = 0;
                p_pos = 0;
                p_halted = 0;
            end
            if (p_halted)
                return;
            while (!done && !has_err)
            begin
                case (p_phase)
                    PH_START:
                        if (c == 0)
                        begin
                            push_tone(KIND_END, 0, 0, 0, 0, 0);
                            p_halted = 1;
                            done = 1;
                        end
                        else
                            p_phase = PH_PRE_BAR;
                    PH_PRE_BAR, PH_POST_BAR:
                        if (c == " ")
                            done = 1;
                        else if (c == "|" && p_phase == PH_PRE_BAR)
                        begin
                            if (p_bar < 65535)
                                p_bar++;
                            p_phase = PH_POST_BAR;
                            done = 1;
                        end
                        else
                        begin
                            code = symbol_code(c);
                            if (code < 0)
                            begin
                                has_err = 1;
                                ec = ERR_BAD_SYMBOL;
                            end
                            else
                            begin
                                p_note = 4'(code);
                                p_phase = PH_AFTER_LETTER;
                                done = 1;
                            end
                        end
                    PH_AFTER_LETTER:
                        if (c == "#")
                        begin
                            if (p_note == CODE_PAUSE || p_note == CODE_E || p_note == CODE_B
                                || p_note == CODE_TEMPO || p_note == CODE_SHIFT)
                            begin
                                has_err = 1;
                                ec = ERR_SHARP;
                            end
                            else
                            begin
                                p_note++;
                                p_phase = PH_AFTER_SHARP;
                                done = 1;
                            end
                        end
                        else
                            p_phase = PH_AFTER_SHARP;
                    PH_AFTER_SHARP:
                        if (p_note == CODE_TEMPO || p_note == CODE_SHIFT)
                        begin
                            if (c != "=")
                            begin
                                has_err = 1;
                                ec = ERR_EQUALS;
                            end
                            else
                            begin
                                p_acc = 0;
                                p_neg = 0;
                                p_phase = PH_SET_START;
                                done = 1;
                            end
                        end
                        else if (p_note == CODE_PAUSE)
                        begin
                            if (c != "@")
                            begin
                                has_err = 1;
                                ec = ERR_AT;
                            end
                            else
                            begin
                                p_acc = 0;
                                p_neg = 0;
                                p_phase = PH_NUM_START;
                                done = 1;
                            end
                        end
                        else
                        begin
                            p_acc = 0;
                            p_neg = 0;
                            p_phase = PH_OCT_START;
                        end
                    PH_SET_START, PH_OCT_START, PH_NUM_START, PH_DEN_START:
                    begin
                        if (c == "-")
                        begin
                            p_neg = 1;
                            done = 1;
                        end
                        p_phase = phase_t'(p_phase + 1);
                    end
                    default:
                        if (c >= "0" && c <= "9")
                        begin
                            p_acc = p_acc * 10 + (c - "0");
                            if (p_acc > 32768)
                                p_acc = 32768;
                            done = 1;
                        end
                        else if (p_phase == PH_SET_DIG)
                        begin
                            if (p_note == CODE_TEMPO)
                                p_tempo = value_done();
                            else
                                p_shift = value_done();
                            p_phase = PH_START;
                        end
                        else if (p_phase == PH_OCT_DIG || p_phase == PH_NUM_DIG)
                        begin
                            if (p_phase == PH_OCT_DIG)
                                p_octave = value_done();
                            else
                                p_numer = value_done();
                            if (c != ((p_phase == PH_OCT_DIG) ? "@" : "/"))
                            begin
                                has_err = 1;
                                ec = (p_phase == PH_OCT_DIG) ? ERR_AT : ERR_SLASH;
                            end
                            else
                            begin
                                p_acc = 0;
                                p_neg = 0;
                                p_phase = phase_t'(p_phase + 1);
                                done = 1;
                            end
                        end
                        else
                        begin
                            den = value_done();
                            if (den == 0 || p_tempo == 0)
                            begin
                                has_err = 1;
                                ec = ERR_ZERO_DIV;
                            end
                            else
                            begin
                                push_tone(KIND_NOTE, p_note, tone_freq(p_note), tone_ms(den),
                                          0, 0);
                                p_phase = PH_START;
                            end
                        end
                endcase
            end
            if (has_err)
            begin
                push_tone(KIND_ERROR, 0, 0, 0, ec, p_pos[15:0]);
                p_halted = 1;
            end
            if (p_pos < 65535)
                p_pos++;
            if (tones_q.size() > n)
                tones_q[$].last = 1;
        end
    endfunction

    function automatic void check_field(input string name, input longint exp_v,
                                        input longint act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fails++;
        end
    endfunction

    // compare each tone beat with the oldest prediction
    always @(posedge clk)
    begin
        tone_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (tones_q.size() == 0)
            begin
                $error("unexpected tone beat, kind %0d", kind);
                fails++;
            end
            else
            begin
                e = tones_q.pop_front();
                check_field("kind", e.kind, kind);
                check_field("note_code", e.note, note_code);
                check_field("freq_hz", e.freq, freq_hz);
                check_field("duration_ms", e.dur, duration_ms);
                check_field("bar_number", e.bar, bar_number);
                check_field("error_code", e.err, error_code);
                check_field("error_pos", e.pos, error_pos);
                check_field("last", e.last, last);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver side stalls
    initial
    begin
        int n;
        out_ready <= 0;
        forever
        begin
            n = $urandom_range(99);
            if (hold_req)
            begin
                out_ready <= 0;
                repeat (600) @(posedge clk);
                hold_req = 0;
            end
            else if (no_stall || n < 70)
            begin
                out_ready <= 1;
                repeat ($urandom_range(20, 1)) @(posedge clk);
            end
            else
            begin
                out_ready <= 0;
                repeat ((n < 95) ? $urandom_range(4, 1) : $urandom_range(80, 30)) @(posedge clk);
            end
        end
    end

    function automatic void add_row(input logic [7:0] c, input logic f, input bit typed = 0,
                                    input logic [1:0] k = KIND_NOTE,
                                    input logic [2:0] e = ERR_BAD_SYMBOL,
                                    input logic [15:0] pos = 0);
        char_row_t r;
        begin
            r = '{c, f, typed, k, e, pos};
            rows_q.push_back(r);
        end
    endfunction

    function automatic void add_text(input logic [7:0] c, input logic f = 0);
        char_row_t r;
        begin
            r = '{c, f, 0, KIND_NOTE, ERR_BAD_SYMBOL, 0};
            text_q.push_back(r);
        end
    endfunction

    function automatic void add_number(input bit small_only);
        int n;
        begin
            if ($urandom_range(99) < 15)
                add_text("-");
            n = $urandom_range(99);
            n = (n < 5) ? 0 : (n < 75 || small_only) ? 1 : (n < 92) ? $urandom_range(3, 2) : 5;
            repeat (n) add_text("0" + $urandom_range(9));
        end
    endfunction

    function automatic void add_length(input bit zero_ok);
        begin
            add_text("@");
            add_number(0);
            add_text("/");
            if (zero_ok && $urandom_range(99) < 5)
                add_text("0");
            else
            begin
                add_text("1" + $urandom_range(8));
                if ($urandom_range(1))
                    add_text("0" + $urandom_range(9));
            end
        end
    endfunction

    // one melody: mostly well-formed tokens, some noise
    function automatic void add_melody();
        string notes = "cdefgabhCDEFGABH";
        int n;
        begin
            add_text(" ", 1);
            repeat ($urandom_range(12, 1))
            begin
                n = $urandom_range(99);
                if (n < 10)
                begin
                    if ($urandom_range(1))
                        add_text(" ");
                    add_text("|");
                    add_text(" ");
                end
                else if (n < 55)
                begin
                    add_text(notes[$urandom_range(15)]);
                    if ($urandom_range(3) == 0)
                        add_text("#");
                    add_number(1);
                    add_length(1);
                end
                else if (n < 65)
                begin
                    add_text($urandom_range(1) ? "p" : "P");
                    add_length(1);
                end
                else if (n < 85)
                begin
                    add_text((n < 75) ? "T" : "s");
                    add_text("=");
                    add_number(0);
                    add_text(" ");
                end
                else if (n < 92)
                    add_text(" ");
                else
                    add_text($urandom_range(255));
            end
            if ($urandom_range(99) < 85)
                add_text(0);
        end
    endfunction

    task automatic send_char(input logic [7:0] c, input logic f, input bit gaps);
        int n;
        begin
            n = $urandom_range(99);
            if (gaps && n >= 60)
            begin
                in_valid <= 0;
                repeat ((n < 90) ? $urandom_range(3, 1) : $urandom_range(60, 20)) @(posedge clk);
            end
            in_valid <= 1;
            ch <= c;
            first <= f;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            parse_char(c, f);
        end
    endtask

    task automatic wait_drained();
        begin
            in_valid <= 0;
            @(posedge clk);
            while (tones_q.size() != 0)
                @(posedge clk);
            repeat (150) @(posedge clk);
        end
    endtask

    initial
    begin
        char_row_t r;
        logic [14:0] tempos[4];
        int sent;
        rst_n <= 0;
        cfg_we <= 0;
        cfg_wdata <= 0;
        in_valid <= 0;
        ch <= 0;
        first <= 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: end, every error, a low note ending on a NUL that gives two beats
        add_row(0, 1, 1, KIND_END);
        add_row("P", 1);
        add_row("#", 0, 1, KIND_ERROR, ERR_SHARP, 1);
        add_row("X", 1, 1, KIND_ERROR, ERR_BAD_SYMBOL, 0);
        add_row("T", 1);
        add_row("x", 0, 1, KIND_ERROR, ERR_EQUALS, 1);
        add_row("p", 1);
        add_row("1", 0, 1, KIND_ERROR, ERR_AT, 1);
        add_row("P", 1);
        add_row("@", 0);
        add_row("1", 0);
        add_row("x", 0, 1, KIND_ERROR, ERR_SLASH, 3);
        add_row("P", 1);
        add_row("@", 0);
        add_row("1", 0);
        add_row("/", 0);
        add_row("0", 0);
        add_row(0, 0, 1, KIND_ERROR, ERR_ZERO_DIV, 5);
        add_row("|", 1);
        add_row("c", 0);
        add_row("#", 0);
        add_row("-", 0);
        add_row("9", 0);
        add_row("@", 0);
        add_row("9", 0);
        add_row("/", 0);
        add_row("1", 0);
        add_row(0, 0, 1, KIND_END);
        foreach (rows_q[i])
        begin
            r = rows_q[i];
            send_char(r.c, r.f, 1);
            if (r.typed && (tones_q.size() == 0 || tones_q[$].kind !== r.kind
                || tones_q[$].err !== r.err || tones_q[$].pos !== r.pos))
            begin
                $error("row %0d: kind/error_code/error_pos expected %0d/%0d/%0d",
                       i, r.kind, r.err, r.pos);
                fails++;
            end
        end
        wait_drained();

        tempos = '{15'd1, 15'd32767, 15'd120, 15'($urandom_range(400, 2))};
        foreach (tempos[ph])
        begin
            cfg_we <= 1;
            cfg_wdata <= tempos[ph];
            @(posedge clk);
            cfg_we <= 0;
            p_start_tempo = tempos[ph];
            no_stall = (ph == 2);
            sent = 0;
            while (sent < 450)
            begin
                text_q.delete();
                add_melody();
                foreach (text_q[i])
                begin
                    send_char(text_q[i].c, text_q[i].f, ph != 2);
                    sent++;
                    if (ph == 0 && sent == 100)
                        hold_req = 1;
                    if (ph == 1 && sent == 200)
                        wait_drained();
                end
            end
            wait_drained();
        end

        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
